// ----- rtl/ssel_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssel_pkg;

	// table geometry
	localparam int ENTRIES = 32;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// operation codes (tuser of the input beat)
	localparam logic [1:0] OP_WRITE_ENTRY = 2'd0;
	localparam logic [1:0] OP_WRITE_REG   = 2'd1;
	localparam logic [1:0] OP_SELECT      = 2'd2;

	// result status codes (tuser of the output beat)
	localparam logic [1:0] STAT_WRITE_DONE = 2'd0;
	localparam logic [1:0] STAT_ON         = 2'd1;
	localparam logic [1:0] STAT_OFF        = 2'd2;
	localparam logic [1:0] STAT_NOT_TITLE  = 2'd3;

	// aspect and crop codes
	localparam logic [1:0] ASPECT_4_3     = 2'd0;
	localparam logic [1:0] ASPECT_16_9    = 2'd3;
	localparam logic [1:0] CROP_WIDE      = 2'd0;
	localparam logic [1:0] CROP_LETTERBOX = 2'd1;
	localparam logic [1:0] CROP_PANSCAN   = 2'd2;

	localparam int PRESENT_BIT = 31;

	// controller to datapath
	typedef struct packed {
		logic load;      // input beat accepted, latch the item
		logic rd_issue;  // read table at scan address, advance it
		logic finish;    // apply the item and load the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_is_scan;  // beat on the input is a title-domain select
		logic addr_last;   // scan address is the last entry
		logic out_free;    // output register can take a result this cycle
	} stat_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] num;
	} stream_t;

	function automatic stream_t stream_of(input logic [31:0] word, input logic [1:0] aspect,
			input logic [1:0] crop);
		stream_t r;
		r.ok  = 1'b0;
		r.num = 5'd0;
		if (aspect == ASPECT_4_3) begin
			r.ok  = 1'b1;
			r.num = word[28:24];
		end else if (aspect == ASPECT_16_9) begin
			case (crop)
				CROP_WIDE: begin
					r.ok  = 1'b1;
					r.num = word[20:16];
				end
				CROP_LETTERBOX: begin
					r.ok  = 1'b1;
					r.num = word[12:8];
				end
				CROP_PANSCAN: begin
					r.ok  = 1'b1;
					r.num = word[4:0];
				end
				default: begin
					r.ok  = 1'b0;
					r.num = 5'd0;
				end
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/ssel_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssel_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                  wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/ssel_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssel_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire ssel_pkg::stat_t stat,
	output ssel_pkg::cmd_t      cmd
);
	import ssel_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign s_tready = ready_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = s_tvalid && ready_q;
		cmd.rd_issue = (state_q == S_SCAN);
		cmd.finish   = (state_q == S_FINISH) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && ready_q) begin
						ready_q <= 1'b0;
						state_q <= stat.in_is_scan ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (stat.addr_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ssel_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssel_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     s_tuser,
	input  wire logic [71:0]    s_tdata,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [1:0]          m_tuser,
	output logic [23:0]         m_tdata,
	input  wire ssel_pkg::cmd_t cmd,
	output ssel_pkg::stat_t     stat
);
	import ssel_pkg::*;

	// latched item
	logic [1:0]  op_q;
	logic [4:0]  idx_q;
	logic [31:0] word_q;
	logic [15:0] regv_q;
	logic [6:0]  req_q;
	logic [1:0]  aspect_q;
	logic [1:0]  crop_q;
	logic        title_q;

	// scan state
	logic [IDX_W-1:0] addr_q;
	logic             rd_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic [31:0]      rdata_s1;
	logic             found_q;
	logic [4:0]       best_q;
	logic [IDX_W-1:0] best_idx_q;

	logic [ENTRIES-1:0] valid_q;
	logic [15:0]        sel_reg_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [15:0] out_reg_q;
	logic [4:0]  out_chosen_q;

	logic        ram_we;
	stream_t     strm;
	logic        req_ok;
	logic        cand;
	logic [1:0]  status_d;
	logic [15:0] reg_d;
	logic [4:0]  chosen_d;

	assign stat.in_is_scan = (s_tuser == OP_SELECT) && s_tdata[64];
	assign stat.addr_last  = (addr_q == IDX_W'(ENTRIES - 1));
	assign stat.out_free   = !out_valid_q || m_tready;

	assign ram_we = cmd.finish && (op_q == OP_WRITE_ENTRY)
		&& ({1'b0, idx_q} < 6'(ENTRIES));

	ssel_ram #(
		.WIDTH(32),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q[IDX_W-1:0]),
		.wdata(word_q),
		.raddr(addr_q),
		.rdata(rdata_s1)
	);

	// candidate test on the entry read last cycle
	assign strm   = stream_of(rdata_s1, aspect_q, crop_q);
	assign req_ok = !req_q[6] && !req_q[5];
	assign cand   = rd_s1 && vld_s1 && rdata_s1[PRESENT_BIT] && strm.ok && req_ok
		&& (strm.num >= req_q[4:0]) && (!found_q || (strm.num < best_q));

	always_comb begin
		status_d = STAT_WRITE_DONE;
		reg_d    = sel_reg_q;
		chosen_d = 5'd0;
		case (op_q)
			OP_WRITE_ENTRY: status_d = STAT_WRITE_DONE;
			OP_WRITE_REG:   reg_d    = regv_q;
			OP_SELECT: begin
				if (!title_q) begin
					status_d = STAT_NOT_TITLE;
				end else if (found_q) begin
					status_d = STAT_ON;
					chosen_d = 5'(best_idx_q);
					reg_d    = {sel_reg_q[15:7], 1'b1, 1'b0, 5'(best_idx_q)};
				end else begin
					status_d = STAT_OFF;
					reg_d    = {sel_reg_q[15:7], 1'b0, sel_reg_q[5:0]};
				end
			end
			default: status_d = STAT_WRITE_DONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= s_tuser;
			idx_q    <= s_tdata[4:0];
			word_q   <= s_tdata[36:5];
			regv_q   <= s_tdata[52:37];
			req_q    <= s_tdata[59:53];
			aspect_q <= s_tdata[61:60];
			crop_q   <= s_tdata[63:62];
			title_q  <= s_tdata[64];
		end
		idx_s1 <= addr_q;
		vld_s1 <= valid_q[addr_q];
		if (cand) begin
			best_q     <= strm.num;
			best_idx_q <= idx_s1;
		end
		if (cmd.finish) begin
			out_status_q <= status_d;
			out_reg_q    <= reg_d;
			out_chosen_q <= chosen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_s1       <= 1'b0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			sel_reg_q   <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_issue;
			if (cmd.load) begin
				addr_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.rd_issue) begin
					addr_q <= addr_q + 1'b1;
				end
				if (cand) begin
					found_q <= 1'b1;
				end
			end
			if (ram_we) begin
				valid_q[idx_q[IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.finish) begin
				sel_reg_q   <= reg_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {3'b000, out_chosen_q, out_reg_q};

	a_found_not_below_req: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_q >= req_q[4:0]) && req_ok)
		else $error("best stream below requested stream");

	a_on_sets_bit6: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == STAT_ON))
			|-> out_reg_q[6] && (out_reg_q[4:0] == out_chosen_q))
		else $error("stream on without bit 6 and index in register");

	a_off_clears_bit6: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q != STAT_ON)) |-> (out_chosen_q == 5'd0)
			&& ((out_status_q != STAT_OFF) || !out_reg_q[6]))
		else $error("no-match result with bit 6 or index set");

	a_finish_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && (sel_reg_q == out_reg_q))
		else $error("finished item missing from output register");

endmodule

`default_nettype wire

// ----- rtl/subpicture_stream_select.sv -----
`timescale 1ns / 1ps
`default_nettype none

// sub-picture stream selector: keeps a table of ENTRIES sub-picture control words and
// a 16-bit select register. each input beat carries one command (in s_tuser) and
// returns exactly one result beat. a table write or a register write is latched on
// accept and then applied, which loads the output register with the result. a
// title-domain select scans the table one entry per cycle through the single read port
// of the table ram: after the latch it reads every entry in turn, drains the last read
// and then applies the result; a select outside the title domain is latched and
// applied like a write. every item is applied only once the output register is free.
// the result goes into an output register, so a waiting result does not hold off the
// next accept; the next result then waits until the output beat is taken. a match
// picks the present entry with the smallest stream number not below the requested
// one, lowest index on ties, and sets bit 6 plus the index in the register; no match
// clears bit 6 only. unknown aspect or crop codes and requests outside 0..31 never
// match. writes to indexes at or above ENTRIES are dropped but still answered.
module subpicture_stream_select (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input beat
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [4:0] entry_index, [36:5] entry_word, [52:37] register_value,
	// [59:53] requested_stream (signed), [61:60] video_aspect, [63:62] crop_mode,
	// [64] in_title_domain, [71:65] zero
	input  wire logic [71:0] s_tdata,
	// [1:0] operation
	input  wire logic [1:0]  s_tuser,
	// result beat
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] subpicture_register, [20:16] chosen_entry, [23:21] zero
	output logic [23:0]      m_tdata,
	// [1:0] status
	output logic [1:0]       m_tuser
);
	import ssel_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: idle, table scan, pipeline drain, result hand-off
	ssel_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// datapath: item latch, table ram with valid bits, best-match tracking,
	// select register and output register
	ssel_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tuser (m_tuser),
		.m_tdata (m_tdata),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

`default_nettype wire
